// File: design/lsh_pkg.sv
package lsh_pkg;

	localparam int CH_W = 8;
	localparam int NUM_CH = 3;
	localparam int PIX_W = CH_W * NUM_CH;
	localparam int WIN_N = 9;
	localparam int WIN_CENTER = 4;

	localparam int FW_W = 11;
	localparam int FH_W = 12;
	localparam int ROW_W = FH_W;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0] FW_RESET = 11'd900;
	localparam logic [FH_W-1:0] FH_RESET = 12'd600;
	localparam logic [FH_W-1:0] FH_MIN = 12'd3;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// where a pass-through result takes its pixel from
	localparam logic [1:0] SRC_CENTER = 2'd0;
	localparam logic [1:0] SRC_EDGE = 2'd1;
	localparam logic [1:0] SRC_LINE = 2'd2;

	typedef logic [CH_W-1:0] chan_t;
	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [WIN_N-1:0][CH_W-1:0] lane_win_t;

	// contrast 0.1 about 128, then brightness -100: floor((L + 1152) / 10) - 100
	localparam int TONE_W = 6;
	localparam int TONE_BIAS = 1152;
	localparam int TONE_DIV = 10;
	localparam int TONE_OFS = 100;
	localparam int TONE_N = 1 << CH_W;

	typedef logic [TONE_N-1:0][TONE_W-1:0] tone_lut_t;

	function automatic tone_lut_t build_tone_lut();
		tone_lut_t lut;
		int v;
		for (int i = 0; i < TONE_N; i++) begin
			v = (i + TONE_BIAS) / TONE_DIV - TONE_OFS;
			lut[i] = TONE_W'(v);
		end
		return lut;
	endfunction

	localparam tone_lut_t TONE_LUT = build_tone_lut();

endpackage

// File: design/lsh_line_buf.sv
module lsh_line_buf
	import lsh_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          mid_we,
	input  pix_t          mid_wdata,
	input  logic          up_we,
	input  logic [AW-1:0] up_waddr,
	input  pix_t          up_wdata,
	output pix_t          up_rd,
	output pix_t          mid_rd
);

	pix_t up_mem [DEPTH];
	pix_t mid_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (up_we) begin
			up_mem[up_waddr] <= up_wdata;
		end
		if (rd_en) begin
			up_rd <= up_mem[rd_addr];
		end
	end

	// middle line is read and rewritten at the same column: read returns the old word
	always_ff @(posedge clk) begin
		if (mid_we) begin
			mid_mem[rd_addr] <= mid_wdata;
		end
		if (rd_en) begin
			mid_rd <= mid_mem[rd_addr];
		end
	end

endmodule

// File: design/lsh_lane.sv
module lsh_lane
	import lsh_pkg::*;
(
	input  logic      clk,
	input  logic      en,
	input  lane_win_t win,
	input  chan_t     base,
	input  logic      sharp,
	output chan_t     result
);

	localparam int SUM_W = CH_W + 3;

	logic [SUM_W-1:0] nbr_sum;
	logic [SUM_W-1:0] center_x8;
	logic [SUM_W-1:0] diff;
	chan_t            lap;
	chan_t            lap_s3;
	chan_t            base_s3;
	logic [TONE_W-1:0] tone;
	logic [CH_W:0]    boosted;

	always_comb begin
		nbr_sum = '0;
		for (int k = 0; k < WIN_N; k++) begin
			if (k != WIN_CENTER) begin
				nbr_sum = nbr_sum + SUM_W'(win[k]);
			end
		end
	end

	assign center_x8 = {win[WIN_CENTER], 3'b000};
	assign diff = nbr_sum - center_x8;

	// clamp the Laplacian to 0..255
	always_comb begin
		if (nbr_sum <= center_x8) begin
			lap = '0;
		end else if (diff > SUM_W'({CH_W{1'b1}})) begin
			lap = '1;
		end else begin
			lap = diff[CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lap_s3 <= lap;
			base_s3 <= base;
		end
	end

	assign tone = TONE_LUT[lap_s3];
	assign boosted = {1'b0, base_s3} + (CH_W + 1)'(tone);

	always_comb begin
		if (!sharp) begin
			result = base_s3;
		end else if (boosted[CH_W]) begin
			result = '1;
		end else begin
			result = boosted[CH_W-1:0];
		end
	end

endmodule

// File: design/lsh_merge.sv
module lsh_merge
	import lsh_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [NUM_CH-1:0][CH_W-1:0]  in_data,
	input  logic                         in_last,
	output logic                         in_ready,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output pix_t                         m_axis_tdata,   // red_out, green_out, blue_out
	output logic                         m_axis_tlast    // frame_last
);

	logic valid_q;
	pix_t data_q;
	logic last_q;

	assign in_ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// lane 0 is red and lands in the low byte
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= pix_t'(in_data);
			last_q <= in_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = data_q;
	assign m_axis_tlast = last_q;

endmodule

// File: design/laplacian_sharpen_3x3_top.sv
// 3x3 Laplacian sharpener for an RGB raster stream. Pixels enter in raster order on the
// slave stream (tuser low) and leave on the master stream one line plus one pixel later,
// each interior pixel raised by a tone term taken from its clamped 8-neighbour Laplacian
// and border pixels unchanged. After the last pixel of a frame, send width + 1 flush
// requests (tuser high) to drain the tail; tlast marks the final pixel. A flush at any
// other time is taken and dropped, and a new pixel during the drain drops the rest.
// One request is taken per clock; its result passes the stage 1, 2 and 3 registers and
// then the output register, which lets input continue while a result waits; only a full
// pipeline behind a stalled master stops input. The rate is set by the two MAX_LINE-word
// line buffers, each read and written once per pixel, the upper one through its own read
// and write ports and the middle one at one address. Writing frame_width or frame_height
// restarts the frame; write only while the block is empty. No clearing pass follows reset.
module laplacian_sharpen_3x3_top
	import lsh_pkg::*;
#(
	parameter int MAX_LINE = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  pix_t                  s_axis_tdata,   // red_in, green_in, blue_in
	input  logic                  s_axis_tuser,   // operation
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output pix_t                  m_axis_tdata,   // red_out, green_out, blue_out
	output logic                  m_axis_tlast    // frame_last
);

	localparam int XW = $clog2(MAX_LINE);
	localparam int LW = $clog2(MAX_LINE + 1);
	localparam int CW = (LW > FW_W) ? LW : FW_W;

	// configuration
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [CW-1:0]    fw_ext;
	logic [LW-1:0]    w_eff;
	logic [LW-1:0]    w_last;
	logic [FH_W-1:0]  h_eff;
	logic [FH_W-1:0]  h_last;

	// input position and drain
	logic [XW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             drain_q;
	logic [LW-1:0]    dcnt_q;
	logic [LW-1:0]    col_ext;
	logic [LW-1:0]    dcnt_m1;

	logic             accept;
	logic             is_pix;
	logic             enter;
	logic             at_col_end;
	logic             at_row_end;
	logic             px_sharp;
	logic             px_center;
	logic             px_edge;
	logic [1:0]       src_sel;
	logic [XW-1:0]    rd_addr;

	// pipeline
	logic             ready1;
	logic             ready2;
	logic             ready3;
	logic             out_ready;
	logic             valid_s1;
	logic             is_pix_s1;
	logic             got_s1;
	logic             sharp_s1;
	logic             last_s1;
	logic             cap_s1;
	logic [1:0]       src_s1;
	logic [XW-1:0]    x_s1;
	pix_t             pix_s1;
	logic             d1;
	logic             valid_s2;
	logic             sharp_s2;
	logic             last_s2;
	pix_t             pass_s2;
	pix_t             pass_sel;
	logic             valid_s3;
	logic             sharp_s3;
	logic             last_s3;

	pix_t             up_rd;
	pix_t             mid_rd;
	pix_t             re_q;
	pix_t [WIN_N-1:0] win_q;

	logic [NUM_CH-1:0][WIN_N-1:0][CH_W-1:0] lane_win;
	logic [NUM_CH-1:0][CH_W-1:0]            lane_res;

	// effective frame size
	assign fw_ext = CW'(fw_q);

	always_comb begin
		priority if (fw_ext < CW'(3)) begin
			w_eff = LW'(3);
		end else if (fw_ext > CW'(MAX_LINE)) begin
			w_eff = LW'(MAX_LINE);
		end else begin
			w_eff = LW'(fw_ext);
		end
	end

	assign w_last = w_eff - LW'(1);
	assign h_eff = (fh_q < FH_MIN) ? FH_MIN : fh_q;
	assign h_last = h_eff - FH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_RESET;
			fh_q <= FH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data[FH_W-1:0];
			endcase
		end
	end

	// request decode
	assign accept = s_axis_tvalid && s_axis_tready;
	assign is_pix = (s_axis_tuser == OP_PIXEL);
	assign enter = is_pix || (s_axis_tuser == OP_FLUSH && drain_q);
	assign col_ext = LW'(col_q);
	assign dcnt_m1 = dcnt_q - LW'(1);
	assign at_col_end = (col_ext == w_last);
	assign at_row_end = (row_q == h_last);

	assign px_sharp = (row_q >= ROW_W'(2)) && (col_q >= XW'(2));
	assign px_center = (row_q != '0) && (col_q != '0);
	assign px_edge = (row_q >= ROW_W'(2)) && (col_q == '0);

	always_comb begin
		if (is_pix) begin
			src_sel = px_edge ? SRC_EDGE : SRC_CENTER;
		end else begin
			// the drain starts with the right edge of the second-to-last row
			src_sel = (dcnt_q == '0) ? SRC_EDGE : SRC_LINE;
		end
	end

	assign rd_addr = is_pix ? col_q : dcnt_m1[XW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			drain_q <= 1'b0;
			dcnt_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
			drain_q <= 1'b0;
		end else if (accept && is_pix) begin
			drain_q <= at_col_end && at_row_end;
			dcnt_q <= '0;
			if (at_col_end) begin
				col_q <= '0;
				row_q <= at_row_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end else if (accept && drain_q) begin
			dcnt_q <= dcnt_q + LW'(1);
			if (dcnt_q == w_eff) begin
				drain_q <= 1'b0;
			end
		end
	end

	// handshake chain, back to front
	assign ready3 = !valid_s3 || out_ready;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;
	assign s_axis_tready = ready1;

	// stage 1: line buffer read
	lsh_line_buf #(
		.DEPTH(MAX_LINE),
		.AW(XW)
	) u_line_buf (
		.clk(clk),
		.rd_en(ready1),
		.rd_addr(rd_addr),
		.mid_we(accept && is_pix),
		.mid_wdata(s_axis_tdata),
		.up_we(d1 && is_pix_s1),
		.up_waddr(x_s1),
		.up_wdata(mid_rd),
		.up_rd(up_rd),
		.mid_rd(mid_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready1) begin
			valid_s1 <= accept && enter;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			is_pix_s1 <= is_pix;
			got_s1 <= is_pix ? (px_center || px_edge) : 1'b1;
			sharp_s1 <= is_pix && px_sharp;
			last_s1 <= !is_pix && (dcnt_q == w_eff);
			cap_s1 <= at_col_end;
			src_s1 <= src_sel;
			x_s1 <= col_q;
			pix_s1 <= s_axis_tdata;
		end
	end

	assign d1 = valid_s1 && ready2;

	// shift the window and keep the last column of the middle line
	always_ff @(posedge clk) begin
		if (d1 && is_pix_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3] <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up_rd;
			win_q[5] <= mid_rd;
			win_q[8] <= pix_s1;
			if (cap_s1) begin
				re_q <= mid_rd;
			end
		end
	end

	// stage 2: Laplacian in the lanes
	always_comb begin
		unique case (src_s1)
			SRC_CENTER: pass_sel = win_q[5];
			SRC_EDGE:   pass_sel = re_q;
			SRC_LINE:   pass_sel = mid_rd;
			default:    pass_sel = win_q[5];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready2) begin
			valid_s2 <= valid_s1 && got_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2) begin
			sharp_s2 <= sharp_s1;
			last_s2 <= last_s1;
			pass_s2 <= pass_sel;
		end
	end

	// stage 3: tone and saturate in the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready3) begin
			sharp_s3 <= sharp_s2;
			last_s3 <= last_s2;
		end
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		for (genvar k = 0; k < WIN_N; k++) begin : g_tap
			assign lane_win[ch][k] = win_q[k][ch*CH_W +: CH_W];
		end

		lsh_lane u_lane (
			.clk(clk),
			.en(ready3),
			.win(lane_win[ch]),
			.base(pass_s2[ch*CH_W +: CH_W]),
			.sharp(sharp_s3),
			.result(lane_res[ch])
		);
	end

	lsh_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s3),
		.in_data(lane_res),
		.in_last(last_s3),
		.in_ready(out_ready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	a_drain_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (col_q == '0 && row_q == '0))
		else $error("drain active away from frame origin");

	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		col_ext < w_eff)
		else $error("input column beyond line width");

	a_drain_count: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> dcnt_q <= w_eff)
		else $error("drain count past end of tail");

	a_window_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready3) |=> $stable(win_q))
		else $error("window moved under a stalled stage 2");

endmodule
